// ===== rtl/core/mtc_pkg.sv =====
// Package for the machine timer: request codes, register offsets,
// control bits and the item and result structures. No dependencies.
`timescale 1ns / 1ps

package mtc_pkg;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_READ  = 2'd1,
		REQ_WRITE = 2'd2
	} req_e_t;

	localparam logic [11:0] OFF_CNT_LO = 12'h000;
	localparam logic [11:0] OFF_CNT_HI = 12'h004;
	localparam logic [11:0] OFF_CMP_LO = 12'h008;
	localparam logic [11:0] OFF_CMP_HI = 12'h00C;
	localparam logic [11:0] OFF_SRST   = 12'hFF0;
	localparam logic [11:0] OFF_CTRL   = 12'hFF8;
	localparam logic [11:0] OFF_SIP    = 12'hFFC;

	localparam int unsigned CTRL_PAUSE   = 0;
	localparam int unsigned CTRL_AUTOCLR = 1;

	localparam logic [15:0] DIV_RESET = 16'd1;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [11:0] addr;
		logic [31:0] wdata;
	} item_t;

	typedef struct packed {
		logic [31:0] rdata;
		logic        timer_irq;
		logic        soft_irq;
	} result_t;

	typedef struct packed {
		logic advance;
		logic fire;
	} flow_t;

endpackage

// ===== rtl/core/mtc_in_stage.sv =====
// Input register of the machine timer: holds one accepted request.
// Depends on mtc_pkg.
`timescale 1ns / 1ps

module mtc_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [47:0]         s_tdata,
	input  logic [1:0]          s_tuser,
	input  logic                advance,
	output logic                valid_s1,
	output mtc_pkg::item_t      item_s1
);

	logic load;

	assign s_tready = !valid_s1 || advance;
	assign load     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.req_type <= s_tuser;
			item_s1.addr     <= s_tdata[11:0];
			item_s1.wdata    <= s_tdata[43:12];
		end
	end

endmodule

// ===== rtl/core/mtc_core.sv =====
// Timer state and its per-request update: counter, compare, prescaler,
// control, software-interrupt and soft-reset words. Depends on mtc_pkg.
`timescale 1ns / 1ps

module mtc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  mtc_pkg::flow_t      flow,
	input  mtc_pkg::item_t      item_s1,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_div,
	output mtc_pkg::result_t    result
);

	logic [63:0] count_q, count_n;
	logic [63:0] cmp_q, cmp_n;
	logic [15:0] presc_q, presc_n;
	logic [31:0] ctrl_q, ctrl_n;
	logic [31:0] sip_q, sip_n;
	logic [31:0] srst_q, srst_n;
	logic [15:0] div_q;
	logic [15:0] div_eff;
	logic [16:0] presc_inc;
	logic [31:0] rd;
	logic        match;

	assign div_eff   = (div_q == 16'd0) ? 16'd1 : div_q;
	assign presc_inc = {1'b0, presc_q} + 17'd1;

	always_comb begin
		count_n = count_q;
		cmp_n   = cmp_q;
		presc_n = presc_q;
		ctrl_n  = ctrl_q;
		sip_n   = sip_q;
		srst_n  = srst_q;
		rd      = 32'd0;
		unique case (mtc_pkg::req_e_t'(item_s1.req_type))
			mtc_pkg::REQ_TICK: begin
				if (!ctrl_q[mtc_pkg::CTRL_PAUSE]) begin
					if (presc_inc >= {1'b0, div_eff}) begin
						presc_n = 16'd0;
						count_n = count_q + 64'd1;
					end else begin
						presc_n = presc_inc[15:0];
					end
				end
			end
			mtc_pkg::REQ_READ: begin
				unique case (item_s1.addr)
					mtc_pkg::OFF_CNT_LO: rd = count_q[31:0];
					mtc_pkg::OFF_CNT_HI: rd = count_q[63:32];
					mtc_pkg::OFF_CMP_LO: rd = cmp_q[31:0];
					mtc_pkg::OFF_CMP_HI: rd = cmp_q[63:32];
					mtc_pkg::OFF_SRST:   rd = srst_q;
					mtc_pkg::OFF_CTRL:   rd = ctrl_q;
					mtc_pkg::OFF_SIP:    rd = sip_q;
					default:             rd = 32'd0;
				endcase
			end
			mtc_pkg::REQ_WRITE: begin
				unique case (item_s1.addr)
					mtc_pkg::OFF_CNT_LO: begin
						count_n = {count_q[63:32], item_s1.wdata};
						presc_n = 16'd0;
					end
					mtc_pkg::OFF_CNT_HI: begin
						count_n = {item_s1.wdata, count_q[31:0]};
						presc_n = 16'd0;
					end
					mtc_pkg::OFF_CMP_LO: cmp_n  = {cmp_q[63:32], item_s1.wdata};
					mtc_pkg::OFF_CMP_HI: cmp_n  = {item_s1.wdata, cmp_q[31:0]};
					mtc_pkg::OFF_SRST:   srst_n = item_s1.wdata;
					mtc_pkg::OFF_CTRL:   ctrl_n = item_s1.wdata;
					mtc_pkg::OFF_SIP:    sip_n  = item_s1.wdata;
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		match = (cmp_n != 64'd0) && (count_n >= cmp_n);
		if (match && ctrl_n[mtc_pkg::CTRL_AUTOCLR]) begin
			count_n = 64'd0;
			presc_n = 16'd0;
		end

		result.rdata     = rd;
		result.timer_irq = match;
		result.soft_irq  = sip_n[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 64'd0;
			cmp_q   <= 64'd0;
			presc_q <= 16'd0;
			ctrl_q  <= 32'd0;
			sip_q   <= 32'd0;
			srst_q  <= 32'd0;
		end else if (flow.fire) begin
			count_q <= count_n;
			cmp_q   <= cmp_n;
			presc_q <= presc_n;
			ctrl_q  <= ctrl_n;
			sip_q   <= sip_n;
			srst_q  <= srst_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= mtc_pkg::DIV_RESET;
		end else if (cfg_we) begin
			div_q <= cfg_div;
		end
	end

endmodule

// ===== rtl/core/mtc_out_stage.sv =====
// Result register of the machine timer and the stall control that
// moves the input register forward. Depends on mtc_pkg.
`timescale 1ns / 1ps

module mtc_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  mtc_pkg::result_t    result,
	output mtc_pkg::flow_t      flow,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [39:0]         m_tdata
);

	logic             m_valid_q;
	mtc_pkg::result_t res_q;

	assign flow.advance = !m_valid_q || m_tready;
	assign flow.fire    = valid_s1 && flow.advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (flow.advance) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (flow.fire) begin
			res_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, res_q.soft_irq, res_q.timer_irq, res_q.rdata};

endmodule

// ===== rtl/core/machine_timer_with_compare.sv =====
// Machine timer with 64-bit counter and compare behind 32-bit registers.
// The result passes through the input register, then the result register;
// throughput one request per cycle while the receiver does not stall, set by the
// combinational counter update and compare between the two registers.
// Reset: asynchronous active low; all timer words clear, divisor returns to 1.
`timescale 1ns / 1ps

module machine_timer_with_compare (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // addr[11:0], wdata[43:12], zero pad
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // rdata[31:0], timer_irq[32], soft_irq[33], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // tick_divisor
);

	logic             valid_s1;
	mtc_pkg::item_t   item_s1;
	mtc_pkg::result_t result;
	mtc_pkg::flow_t   flow;

	assign cfg_ready = 1'b1;

	mtc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (flow.advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mtc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.flow    (flow),
		.item_s1 (item_s1),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_div (cfg_data),
		.result  (result)
	);

	mtc_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.result   (result),
		.flow     (flow),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== rtl/core/mtc_checker.sv =====
// Port-level checks for the machine timer, bound to the top level.
// Depends on machine_timer_with_compare.
`timescale 1ns / 1ps

module mtc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_back_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output stall");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 (!m_tvalid || m_tready) |=> m_tvalid)
		else $error("transfer produced no result");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:34] == 6'd0)
		else $error("result padding not zero");

endmodule

bind machine_timer_with_compare mtc_checker u_mtc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);

// ===== bench/mtc_result_checker.sv =====
// Checker for the machine timer: watches the request, result and divisor channels,
// keeps its own copy of the timer state and compares every result transfer.
// Depends on mtc_pkg for request codes, register offsets and control bit positions.
`timescale 1ns / 1ps

module mtc_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,   // addr[11:0], wdata[43:12], zero pad
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // rdata[31:0], timer_irq[32], soft_irq[33], zero pad
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,  // tick_divisor
	output int unsigned mismatch_count,
	output int unsigned outstanding
);

	logic [63:0] count_value;
	logic [63:0] compare_value;
	logic [15:0] prescale_phase;
	logic [31:0] control_word;
	logic [31:0] softirq_word;
	logic [31:0] soft_reset_word;
	logic [15:0] tick_divisor;
	int unsigned fails;
	mtc_pkg::result_t expected_results[$];

	task automatic advance_timer(input logic [1:0] kind, input logic [11:0] offset,
			input logic [31:0] wdata);
		logic [16:0] next_phase;
		logic [16:0] divisor_eff;
		logic        match;
		mtc_pkg::result_t res;
		res = '0;
		divisor_eff = (tick_divisor == 16'd0) ? 17'd1 : {1'b0, tick_divisor};
		case (kind)
		mtc_pkg::REQ_TICK: begin
			if (!control_word[mtc_pkg::CTRL_PAUSE]) begin
				next_phase = {1'b0, prescale_phase} + 17'd1;
				if (next_phase >= divisor_eff) begin
					prescale_phase = '0;
					count_value = count_value + 64'd1;
				end else begin
					prescale_phase = next_phase[15:0];
				end
			end
		end
		mtc_pkg::REQ_READ: begin
			case (offset)
			mtc_pkg::OFF_CNT_LO: res.rdata = count_value[31:0];
			mtc_pkg::OFF_CNT_HI: res.rdata = count_value[63:32];
			mtc_pkg::OFF_CMP_LO: res.rdata = compare_value[31:0];
			mtc_pkg::OFF_CMP_HI: res.rdata = compare_value[63:32];
			mtc_pkg::OFF_SRST:   res.rdata = soft_reset_word;
			mtc_pkg::OFF_CTRL:   res.rdata = control_word;
			mtc_pkg::OFF_SIP:    res.rdata = softirq_word;
			default:             res.rdata = '0;
			endcase
		end
		mtc_pkg::REQ_WRITE: begin
			case (offset)
			mtc_pkg::OFF_CNT_LO: begin
				count_value[31:0] = wdata;
				prescale_phase = '0;
			end
			mtc_pkg::OFF_CNT_HI: begin
				count_value[63:32] = wdata;
				prescale_phase = '0;
			end
			mtc_pkg::OFF_CMP_LO: compare_value[31:0] = wdata;
			mtc_pkg::OFF_CMP_HI: compare_value[63:32] = wdata;
			mtc_pkg::OFF_SRST:   soft_reset_word = wdata;
			mtc_pkg::OFF_CTRL:   control_word = wdata;
			mtc_pkg::OFF_SIP:    softirq_word = wdata;
			default:             ;
			endcase
		end
		default: ;
		endcase
		match = (compare_value != 64'd0) && (count_value >= compare_value);
		if (match && control_word[mtc_pkg::CTRL_AUTOCLR]) begin
			count_value = '0;
			prescale_phase = '0;
		end
		res.timer_irq = match;
		res.soft_irq = softirq_word[0];
		expected_results.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		mtc_pkg::result_t want;
		mtc_pkg::result_t got;
		if (!arst_n) begin
			count_value = '0;
			compare_value = '0;
			prescale_phase = '0;
			control_word = '0;
			softirq_word = '0;
			soft_reset_word = '0;
			tick_divisor = mtc_pkg::DIV_RESET;
			fails = 0;
			expected_results.delete();
			mismatch_count <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.rdata = m_tdata[31:0];
				got.timer_irq = m_tdata[32];
				got.soft_irq = m_tdata[33];
				if (expected_results.size() == 0) begin
					if (fails < 10)
						$display("%0t: result transfer with none expected: %s",
							$realtime, $sformatf("rdata=%h irq=%b sip=%b",
							got.rdata, got.timer_irq, got.soft_irq));
					fails++;
				end else begin
					want = expected_results.pop_front();
					if (got.rdata !== want.rdata || got.timer_irq !== want.timer_irq ||
							got.soft_irq !== want.soft_irq) begin
						if (fails < 10)
							$display("%0t: mismatch %s",
								$realtime, $sformatf(
								"rdata %h/%h timer_irq %b/%b soft_irq %b/%b (exp/act)",
								want.rdata, got.rdata, want.timer_irq, got.timer_irq,
								want.soft_irq, got.soft_irq));
						fails++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				tick_divisor = cfg_data;
			if (s_tvalid && s_tready)
				advance_timer(s_tuser, s_tdata[11:0], s_tdata[43:12]);
			mismatch_count <= fails;
			outstanding <= expected_results.size();
		end
	end

endmodule

// ===== bench/tb_machine_timer_with_compare.sv =====
// Top of the machine timer bench: clock, reset, directed and random register traffic
// with random sender gaps and receiver stalls, divisor changes between phases.
// Depends on mtc_pkg, machine_timer_with_compare and mtc_result_checker.
`timescale 1ns / 1ps

module tb_machine_timer_with_compare;

	localparam logic [1:0]  REQ_NONE         = 2'd3;
	localparam logic [11:0] OFF_UNALIGNED    = 12'h013;
	localparam logic [11:0] OFF_UNMAPPED     = 12'h001;
	localparam logic [11:0] OFF_TOP          = 12'hFFF;
	localparam logic [31:0] CTRL_PAUSE_BIT   = 32'd1 << mtc_pkg::CTRL_PAUSE;
	localparam logic [31:0] CTRL_AUTOCLR_BIT = 32'd1 << mtc_pkg::CTRL_AUTOCLR;
	localparam logic [31:0] ALL_ONES         = 32'hFFFF_FFFF;
	localparam int unsigned ITEMS_PER_PHASE  = 132;
	localparam int unsigned DRAIN_LIMIT      = 100000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic [15:0] stall_cycle = '0;
	int unsigned mismatch_count;
	int unsigned outstanding;
	logic [11:0] mapped_offsets [7] = '{mtc_pkg::OFF_CNT_LO, mtc_pkg::OFF_CNT_HI,
		mtc_pkg::OFF_CMP_LO, mtc_pkg::OFF_CMP_HI, mtc_pkg::OFF_SRST, mtc_pkg::OFF_CTRL,
		mtc_pkg::OFF_SIP};
	logic [15:0] divisor_plan [6] = '{16'd0, 16'd65535, 16'd3, 16'd1, 16'd2, 16'd7};

	machine_timer_with_compare dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	mtc_result_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 16'd1;
		case (stall_cycle[8:7])
		2'd0: m_tready <= 1'b1;
		2'd1: m_tready <= ($urandom_range(3, 0) != 0);
		2'd2: m_tready <= ($urandom_range(3, 0) == 0);
		default: m_tready <= stall_cycle[0];
		endcase
	end

	task automatic send_request(input logic [1:0] kind, input logic [11:0] offset,
			input logic [31:0] wdata);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {4'd0, wdata, offset};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic pause_sender(input int unsigned cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_results();
		int unsigned waited;
		waited = 0;
		s_tvalid <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while (outstanding != 0 && waited < DRAIN_LIMIT);
	endtask

	task automatic write_divisor(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_request();
		int unsigned pick;
		logic [1:0]  kind;
		logic [11:0] offset;
		logic [31:0] wdata;
		pick = $urandom_range(99, 0);
		wdata = $urandom();
		if ($urandom_range(9, 0) == 0)
			offset = 12'($urandom());
		else
			offset = mapped_offsets[$urandom_range(6, 0)];
		if (pick < 45)
			kind = mtc_pkg::REQ_TICK;
		else if (pick < 65)
			kind = mtc_pkg::REQ_READ;
		else if (pick < 95)
			kind = mtc_pkg::REQ_WRITE;
		else
			kind = REQ_NONE;
		if (kind == mtc_pkg::REQ_WRITE && $urandom_range(3, 0) != 0) begin
			case (offset)
			mtc_pkg::OFF_CNT_LO: wdata = $urandom_range(1, 0) ? $urandom_range(60, 0) :
				ALL_ONES - $urandom_range(3, 0);
			mtc_pkg::OFF_CNT_HI: wdata = $urandom_range(1, 0) ? 32'd0 : ALL_ONES;
			mtc_pkg::OFF_CMP_LO: wdata = $urandom_range(80, 0);
			mtc_pkg::OFF_CMP_HI: wdata = 32'd0;
			mtc_pkg::OFF_CTRL:   wdata = $urandom_range(3, 0);
			default:             ;
			endcase
		end
		send_request(kind, offset, wdata);
	endtask

	initial begin
		int unsigned issued;
		int unsigned burst;
		int unsigned gap;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (mapped_offsets[i])
			send_request(mtc_pkg::REQ_READ, mapped_offsets[i], $urandom());
		send_request(mtc_pkg::REQ_WRITE, mtc_pkg::OFF_SRST, ALL_ONES);
		send_request(mtc_pkg::REQ_READ, mtc_pkg::OFF_SRST, 32'd0);
		send_request(mtc_pkg::REQ_WRITE, mtc_pkg::OFF_SIP, ALL_ONES);
		send_request(mtc_pkg::REQ_WRITE, mtc_pkg::OFF_SIP, ALL_ONES - 32'd1);
		send_request(mtc_pkg::REQ_WRITE, mtc_pkg::OFF_CNT_LO, ALL_ONES);
		send_request(mtc_pkg::REQ_WRITE, mtc_pkg::OFF_CNT_HI, ALL_ONES);
		send_request(mtc_pkg::REQ_TICK, mtc_pkg::OFF_CNT_LO, ALL_ONES);
		send_request(mtc_pkg::REQ_WRITE, mtc_pkg::OFF_CMP_LO, 32'd5);
		send_request(mtc_pkg::REQ_WRITE, mtc_pkg::OFF_CNT_LO, 32'd4);
		send_request(mtc_pkg::REQ_TICK, mtc_pkg::OFF_CNT_LO, 32'd0);
		send_request(mtc_pkg::REQ_WRITE, mtc_pkg::OFF_CTRL, CTRL_AUTOCLR_BIT);
		send_request(mtc_pkg::REQ_WRITE, mtc_pkg::OFF_CTRL, CTRL_PAUSE_BIT | CTRL_AUTOCLR_BIT);
		send_request(mtc_pkg::REQ_WRITE, mtc_pkg::OFF_CNT_LO, 32'd7);
		send_request(mtc_pkg::REQ_TICK, mtc_pkg::OFF_CNT_LO, 32'd0);
		send_request(mtc_pkg::REQ_WRITE, mtc_pkg::OFF_CTRL, 32'd0);
		send_request(mtc_pkg::REQ_WRITE, OFF_UNALIGNED, ALL_ONES);
		send_request(mtc_pkg::REQ_READ, OFF_UNMAPPED, 32'd0);
		send_request(REQ_NONE, OFF_TOP, $urandom());
		send_request(mtc_pkg::REQ_WRITE, mtc_pkg::OFF_CMP_HI, ALL_ONES);
		send_request(mtc_pkg::REQ_WRITE, mtc_pkg::OFF_CMP_LO, ALL_ONES);
		drain_results();

		for (int p = 0; p < 7; p++) begin
			write_divisor((p < 6) ? divisor_plan[p] : 16'($urandom_range(60, 4)));
			issued = 0;
			while (issued < ITEMS_PER_PHASE) begin
				burst = $urandom_range(40, 1);
				for (int i = 0; i < burst && issued < ITEMS_PER_PHASE; i++) begin
					random_request();
					issued++;
				end
				gap = $urandom_range(2, 0) == 0 ? 0 : $urandom_range(6, 1);
				if ($urandom_range(15, 0) == 0)
					drain_results();
				else if (gap != 0)
					pause_sender(gap);
			end
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
